// ===== rtl/afb_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame builder.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package afb_pkg;

  localparam logic [15:0] HOST_RESET      = 16'h0101;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [3:0]  HEAD_LAST       = 4'd10;
  localparam int          QUEUE_DEPTH_DEF = 4;

  typedef enum logic {
    ACT_HEAD = 1'b0,
    ACT_DATA = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI
  } back_state_t;

  typedef struct packed {
    action_t     kind;
    logic        close;
    logic [15:0] dest_address;
    logic [31:0] register_address;
    logic [7:0]  command_code;
    logic [15:0] payload_count;
    logic [7:0]  data_byte;
  } frame_cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/afb_ifs.sv =====
// Valid/ready channel interfaces for the frame builder's input items and output bytes.
// No dependencies.
`timescale 1ns / 1ps

interface afb_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] dest_address;
  logic [31:0] register_address;
  logic [7:0]  command_code;
  logic [15:0] payload_count;
  logic [7:0]  data_byte;

  modport source (
    output valid, action, dest_address, register_address, command_code,
           payload_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, dest_address, register_address, command_code,
           payload_count, data_byte,
    output ready
  );
endinterface

interface afb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ===== rtl/afb_front.sv =====
// Front end: accepts input transactions, tracks the open frame, drops stray payload.
// Depends on afb_pkg and afb_in_if.
`timescale 1ns / 1ps

module afb_front (
  input  logic               clk,
  input  logic               rst,
  afb_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output afb_pkg::frame_cmd_t push_cmd
);
  import afb_pkg::*;

  logic [15:0] bytes_left;
  logic        accept;
  logic        is_head;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_head     = (action_t'(in_ch.action) == ACT_HEAD);
  assign push        = accept && (is_head || (bytes_left != 16'd0));

  always_comb begin
    push_cmd.kind             = action_t'(in_ch.action);
    push_cmd.close            = is_head ? (in_ch.payload_count == 16'd0)
                                        : (bytes_left == 16'd1);
    push_cmd.dest_address     = in_ch.dest_address;
    push_cmd.register_address = in_ch.register_address;
    push_cmd.command_code     = in_ch.command_code;
    push_cmd.payload_count    = in_ch.payload_count;
    push_cmd.data_byte        = in_ch.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 16'd0;
    end else if (accept) begin
      if (is_head) begin
        bytes_left <= in_ch.payload_count;
      end else if (bytes_left != 16'd0) begin
        bytes_left <= bytes_left - 16'd1;
      end
    end
  end

endmodule

// ===== rtl/afb_queue.sv =====
// Small register FIFO of frame commands between front and back end.
// Depends on afb_pkg.
`timescale 1ns / 1ps

module afb_queue #(
  parameter int DEPTH = afb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afb_pkg::frame_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output afb_pkg::frame_cmd_t head
);
  import afb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_cmd_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/afb_back.sv =====
// Back end: serializes head, payload and CRC bytes into the registered output stage.
// Depends on afb_pkg and afb_out_if.
`timescale 1ns / 1ps

module afb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         host_address,
  input  logic                q_valid,
  input  afb_pkg::frame_cmd_t q_head,
  output logic                pop,
  afb_out_if.source           out_ch
);
  import afb_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [3:0]  idx;
  logic [3:0]  idx_next;
  frame_cmd_t  cur;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        advance;
  logic        emitting;
  logic        last;
  logic [7:0]  byte_sel;
  logic [87:0] head_vec;
  logic [6:0]  head_off;

  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_byte;
  assign out_ch.frame_end = frame_end;

  assign advance  = !out_valid || out_ch.ready;
  assign emitting = advance && (state != ST_IDLE);
  assign head_vec = {host_address, cur.dest_address, cur.register_address,
                     cur.command_code, cur.payload_count};
  assign head_off = {HEAD_LAST - idx, 3'b000};
  assign crc_in   = ((state == ST_HEAD) && (idx == 4'd0)) ? CRC_INIT : crc;

  always_comb begin
    case (state)
      ST_HEAD:   byte_sel = head_vec[head_off +: 8];
      ST_DATA:   byte_sel = cur.data_byte;
      ST_CRC_LO: byte_sel = crc[7:0];
      ST_CRC_HI: byte_sel = crc[15:8];
      default:   byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    last       = 1'b0;
    case (state)
      ST_HEAD: begin
        if (idx == HEAD_LAST) begin
          last       = !cur.close;
          state_next = cur.close ? ST_CRC_LO : ST_IDLE;
        end else begin
          idx_next = idx + 4'd1;
        end
      end
      ST_DATA: begin
        last       = !cur.close;
        state_next = cur.close ? ST_CRC_LO : ST_IDLE;
      end
      ST_CRC_LO: state_next = ST_CRC_HI;
      ST_CRC_HI: begin
        last       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (!emitting) begin
      state_next = state;
      idx_next   = idx;
    end
    pop = q_valid && ((state == ST_IDLE) || (emitting && last));
    if (pop) begin
      state_next = (q_head.kind == ACT_HEAD) ? ST_HEAD : ST_DATA;
      idx_next   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 4'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (emitting && ((state == ST_HEAD) || (state == ST_DATA))) begin
      crc <= crc_byte(crc_in, byte_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emitting;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      out_byte  <= byte_sel;
      frame_end <= (state == ST_CRC_HI);
    end
  end

`ifndef SYNTHESIS
  a_head_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD) |-> (idx <= HEAD_LAST))
    else $error("head byte index out of range");

  a_crc_hi_ends: assert property (@(posedge clk) disable iff (rst)
    (emitting && (state == ST_CRC_HI)) |=> (out_valid && frame_end))
    else $error("high CRC byte not marked as frame end");

  a_crc_lo_then_hi: assert property (@(posedge clk) disable iff (rst)
    (emitting && (state == ST_CRC_LO)) |=> (state == ST_CRC_HI))
    else $error("low CRC byte not followed by high CRC byte");

  a_no_pop_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (pop && (state == ST_CRC_LO)) |-> 1'b0)
    else $error("queue popped between CRC bytes");
`endif

endmodule

// ===== rtl/addressed_frame_builder_crc16.sv =====
// Frame builder: header and payload transactions in, frame bytes with CRC-16 out.
// A header accepted by an idle block passes the queue slot, the back-end state and the output register.
// Throughput: one output byte per cycle while out_ch.ready holds; a payload transaction per cycle mid-frame;
// a header gives 11 bytes (13 with CRC), a closing payload 3 bytes (its data byte and the CRC).
// Reset (synchronous, rst high): no frame open, queue and output empty, host address 0x0101.
`timescale 1ns / 1ps

module addressed_frame_builder_crc16 #(
  parameter int QUEUE_DEPTH = afb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  afb_in_if.sink      in_ch,
  afb_out_if.source   out_ch
);
  import afb_pkg::*;

  logic [15:0] host_address;
  logic        push;
  frame_cmd_t  push_cmd;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  frame_cmd_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_address <= HOST_RESET;
    end else if (cfg_write) begin
      host_address <= cfg_data;
    end
  end

  afb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  afb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  afb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .host_address (host_address),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .out_ch       (out_ch)
  );

endmodule
